FILE: rtl/range_add_range_sum_tree_unit_defines.svh
// Assertion macros shared by the range add / range sum tree RTL.
`ifndef RANGE_ADD_RANGE_SUM_TREE_UNIT_DEFINES_SVH
`define RANGE_ADD_RANGE_SUM_TREE_UNIT_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define RARS_ASSERT_NOW(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

// Condition holds in the cycle after the trigger.
`define RARS_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

FILE: rtl/rars_pkg.sv
// Package with types and constants of the range add / range sum tree unit.
package rars_pkg;

  localparam int unsigned LEAVES_DEF = 1024;
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned POS_W      = 11;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned SUM_W      = 64;

  // Operation codes carried in tuser.
  typedef enum logic [FUNC_W-1:0] {
    FN_QUERY = 2'd0,
    FN_ADD   = 2'd1,
    FN_SET   = 2'd2
  } func_t;

  // One operation as it enters the sequencer.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0]  lo;
    logic [POS_W-1:0]  hi;
    logic [VAL_W-1:0]  value;
  } item_t;

  // One binary indexed tree entry: difference sum and position-weighted difference sum.
  typedef struct packed {
    logic [SUM_W-1:0] s2;
    logic [SUM_W-1:0] s1;
  } fen_word_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PRE_RD,
    ST_PRE_ACC,
    ST_PRE_MUL,
    ST_PRE_END,
    ST_UPD_MUL,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_DONE
  } state_t;

endpackage

FILE: rtl/rars_mem.sv
// Single-port memory with registered read data, holding the binary indexed tree entries.
module rars_mem #(
  parameter int unsigned DEPTH = 1025,
  parameter int unsigned AW    = 11,
  parameter int unsigned DW    = 128
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/rars_ctrl.sv
// Sequencer and shared multiply/add datapath walking the binary indexed tree memory.
`include "range_add_range_sum_tree_unit_defines.svh"

module rars_ctrl #(
  parameter int unsigned LEAVES = rars_pkg::LEAVES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [rars_pkg::POS_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  rars_pkg::item_t            in_item,
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic [rars_pkg::SUM_W-1:0] res_sum
);

  localparam int unsigned AW    = $clog2(LEAVES + 1);
  localparam int unsigned UW    = $clog2(2 * LEAVES + 1);
  localparam int unsigned DEPTH = LEAVES + 1;
  localparam int unsigned SW    = rars_pkg::SUM_W;
  localparam logic [UW-1:0] LEAVES_U = UW'(LEAVES);

  rars_pkg::state_t    state, state_next;
  rars_pkg::fen_word_t rd_word, wr_word;

  logic [AW-1:0] n_q;
  logic [1:0]    op_q;
  logic [AW-1:0] lo_q, hi_q;
  logic [SW-1:0] val_q;
  logic [UW-1:0] idx;
  logic [SW-1:0] acc1, acc2, phi, dv, prod, res;
  logic          pass;
  logic          mem_we;

  // Decode of the arriving item.
  logic [31:0]   n32, lo32, hi32, hi_eff, cfg32, n_new;
  logic          item_ok;
  logic [SW-1:0] val_ext;

  always_comb begin
    n32     = 32'(n_q);
    lo32    = 32'(in_item.lo);
    hi32    = 32'(in_item.hi);
    hi_eff  = hi32;
    item_ok = 1'b0;
    val_ext = SW'(signed'(in_item.value));
    unique case (in_item.func)
      rars_pkg::FN_QUERY, rars_pkg::FN_ADD: begin
        item_ok = (lo32 < hi32) && (hi32 <= n32);
      end
      rars_pkg::FN_SET: begin
        item_ok = lo32 < n32;
        hi_eff  = lo32 + 32'd1;
      end
      default: begin
        item_ok = 1'b0;
      end
    endcase
  end

  // Clamp of a new leaf count.
  always_comb begin
    cfg32 = 32'(cfg_wdata);
    if (cfg32 == 32'd0) begin
      n_new = 32'd1;
    end else if (cfg32 > 32'(LEAVES)) begin
      n_new = 32'(LEAVES);
    end else begin
      n_new = cfg32;
    end
  end

  // Shared operands: prefix position, update position and signed delta.
  logic [UW-1:0] lowbit;
  logic [AW-1:0] ppos, upos, mul_b;
  logic [SW-1:0] d_signed, mul_a, pre_val, cur;

  always_comb begin
    lowbit   = idx & (~idx + UW'(1));
    ppos     = pass ? lo_q : hi_q;
    upos     = pass ? hi_q : lo_q;
    d_signed = pass ? (~dv + SW'(1)) : dv;
    mul_a    = (state == rars_pkg::ST_PRE_MUL) ? acc1 : d_signed;
    mul_b    = (state == rars_pkg::ST_PRE_MUL) ? ppos : upos;
    pre_val  = prod - acc2;
    cur      = phi - pre_val;
    wr_word.s1 = rd_word.s1 + d_signed;
    wr_word.s2 = rd_word.s2 + prod;
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rars_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    mem_we     = 1'b0;
    unique case (state)
      rars_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        if (idx == LEAVES_U) begin
          state_next = rars_pkg::ST_IDLE;
        end
      end
      rars_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!item_ok) begin
            state_next = rars_pkg::ST_DONE;
          end else if (in_item.func == rars_pkg::FN_ADD) begin
            state_next = rars_pkg::ST_UPD_MUL;
          end else begin
            state_next = rars_pkg::ST_PRE_RD;
          end
        end
      end
      rars_pkg::ST_PRE_RD: begin
        state_next = (idx == '0) ? rars_pkg::ST_PRE_MUL : rars_pkg::ST_PRE_ACC;
      end
      rars_pkg::ST_PRE_ACC: begin
        state_next = rars_pkg::ST_PRE_RD;
      end
      rars_pkg::ST_PRE_MUL: begin
        state_next = rars_pkg::ST_PRE_END;
      end
      rars_pkg::ST_PRE_END: begin
        if (!pass) begin
          state_next = rars_pkg::ST_PRE_RD;
        end else if (op_q == rars_pkg::FN_QUERY) begin
          state_next = rars_pkg::ST_DONE;
        end else begin
          state_next = rars_pkg::ST_UPD_MUL;
        end
      end
      rars_pkg::ST_UPD_MUL: begin
        state_next = rars_pkg::ST_UPD_RD;
      end
      rars_pkg::ST_UPD_RD: begin
        if (idx > LEAVES_U) begin
          state_next = pass ? rars_pkg::ST_DONE : rars_pkg::ST_UPD_MUL;
        end else begin
          state_next = rars_pkg::ST_UPD_WR;
        end
      end
      rars_pkg::ST_UPD_WR: begin
        mem_we     = 1'b1;
        state_next = rars_pkg::ST_UPD_RD;
      end
      rars_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = rars_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rars_pkg::ST_CLEAR;
      end
    endcase
    // A size write restarts the clearing pass.
    if (cfg_we) begin
      state_next = rars_pkg::ST_CLEAR;
    end
  end

  // Leaf count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      n_q <= AW'(LEAVES);
    end else if (cfg_we) begin
      n_q <= AW'(n_new);
    end
  end

  // Datapath registers, stepped by the sequencer.
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      idx <= '0;
    end else begin
      unique case (state)
        rars_pkg::ST_CLEAR: begin
          idx <= idx + UW'(1);
        end
        rars_pkg::ST_IDLE: begin
          if (in_valid) begin
            op_q  <= in_item.func;
            lo_q  <= AW'(lo32);
            hi_q  <= AW'(hi_eff);
            val_q <= val_ext;
            dv    <= val_ext;
            pass  <= 1'b0;
            acc1  <= '0;
            acc2  <= '0;
            res   <= '0;
            idx   <= UW'(hi_eff);
          end
        end
        rars_pkg::ST_PRE_ACC: begin
          acc1 <= acc1 + rd_word.s1;
          acc2 <= acc2 + rd_word.s2;
          idx  <= idx - lowbit;
        end
        rars_pkg::ST_PRE_MUL: begin
          prod <= SW'(mul_a * mul_b);
        end
        rars_pkg::ST_PRE_END: begin
          if (!pass) begin
            phi  <= pre_val;
            pass <= 1'b1;
            acc1 <= '0;
            acc2 <= '0;
            idx  <= UW'(lo_q);
          end else if (op_q == rars_pkg::FN_QUERY) begin
            res <= cur;
          end else begin
            dv   <= val_q - cur;
            pass <= 1'b0;
          end
        end
        rars_pkg::ST_UPD_MUL: begin
          prod <= SW'(mul_a * mul_b);
          idx  <= UW'(upos) + UW'(1);
        end
        rars_pkg::ST_UPD_RD: begin
          if (idx > LEAVES_U) begin
            pass <= 1'b1;
            res  <= '0;
          end
        end
        rars_pkg::ST_UPD_WR: begin
          idx <= idx + lowbit;
        end
        default: begin
          idx <= idx;
        end
      endcase
    end
  end

  assign res_sum = res;

  // Binary indexed tree storage: cleared words during the clearing pass, else updates.
  logic [$bits(rars_pkg::fen_word_t)-1:0] mem_wdata, mem_rdata;

  assign mem_wdata = (state == rars_pkg::ST_CLEAR) ? '0 : wr_word;
  assign rd_word   = rars_pkg::fen_word_t'(mem_rdata);

  rars_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    ($bits(rars_pkg::fen_word_t))
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (idx[AW-1:0]),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Checks on the sequencer.
  `RARS_ASSERT_NOW(a_acc_idx_nonzero, state == rars_pkg::ST_PRE_ACC, idx != '0, "prefix step at index zero")
  `RARS_ASSERT_NOW(a_wr_idx_range, state == rars_pkg::ST_UPD_WR, (idx != '0) && (idx <= LEAVES_U), "update write out of range")
  `RARS_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready && !cfg_we, state != rars_pkg::ST_IDLE, "accepted item left sequencer idle")
  `RARS_ASSERT_NEXT(a_result_held, (state == rars_pkg::ST_DONE) && !res_ready && !cfg_we, state == rars_pkg::ST_DONE, "result dropped before transfer")

endmodule

FILE: rtl/range_add_range_sum_tree_unit.sv
// Range add / range sum over up to LEAVES elements, one operation at a time.
// Each operation takes one input transfer and gives exactly one result transfer
// (the range sum for a query, zero otherwise). Internally the array is kept as
// a pair of binary indexed sums in one single-port memory; every walk step is a
// memory read followed by an accumulate or a write. A query walks two prefixes,
// a range add two update chains, and a point set both. After reset and after
// every write of the leaf count all LEAVES+1 memory words are cleared, during
// which no input transfer is taken. A finished result waits in an output
// register, so the next input transfer can be taken before it is collected.
module range_add_range_sum_tree_unit #(
  parameter int unsigned LEAVES = rars_pkg::LEAVES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Leaf count register.
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata, // size_in_use
  // Operation stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // range_low[10:0], range_high[21:11], value[53:22]
  input  logic [1:0]  s_tuser,   // func[1:0]
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // sum[63:0]
);

  rars_pkg::item_t in_item;
  logic            res_valid, res_ready;
  logic [63:0]     res_sum;

  // Unpack the input transfer.
  always_comb begin
    in_item.func  = s_tuser;
    in_item.lo    = s_tdata[10:0];
    in_item.hi    = s_tdata[21:11];
    in_item.value = s_tdata[53:22];
  end

  rars_ctrl #(
    .LEAVES (LEAVES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_sum   (res_sum)
  );

  // Output register: loaded when empty or being emptied.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= res_sum;
    end
  end

endmodule
